### rtl/core/kes_pkg.sv
// Package for the key event scanner: payload structs, register indexes, event codes.
// Used by every module under rtl/core; depends on nothing.
package kes_pkg;

   localparam int TimeBits  = 32;
   localparam int TouchBits = 16;
   localparam int NumEvents = 7;

   localparam logic [3:0] EV_LEFT_DOWN  = 4'd0;
   localparam logic [3:0] EV_RIGHT_DOWN = 4'd2;
   localparam logic [3:0] EV_DIT_DOWN   = 4'd4;
   localparam logic [3:0] EV_DAH_DOWN   = 4'd6;
   localparam logic [3:0] EV_ENC_CW     = 4'd8;
   localparam logic [3:0] EV_ENC_CCW    = 4'd9;
   localparam logic [3:0] EV_ENC_SHORT  = 4'd10;
   localparam logic [3:0] EV_ENC_LONG   = 4'd11;
   localparam logic [3:0] EV_AUX_SHORT  = 4'd12;
   localparam logic [3:0] EV_AUX_LONG   = 4'd13;

   localparam logic [2:0] REG_LEFT_ON   = 3'd0;
   localparam logic [2:0] REG_LEFT_OFF  = 3'd1;
   localparam logic [2:0] REG_RIGHT_ON  = 3'd2;
   localparam logic [2:0] REG_RIGHT_OFF = 3'd3;
   localparam logic [2:0] REG_DEBOUNCE  = 3'd4;
   localparam logic [2:0] REG_LONG_TIME = 3'd5;
   localparam logic [2:0] REG_HOLD_LIM  = 3'd6;
   localparam logic [2:0] REG_DETENT    = 3'd7;

   typedef struct packed {
      logic [TimeBits-1:0]  now_ms;
      logic [TouchBits-1:0] left_touch_reading;
      logic [TouchBits-1:0] right_touch_reading;
      logic                 dit_paddle_closed;
      logic                 dah_paddle_closed;
      logic                 encoder_button_pressed;
      logic                 aux_button_pressed;
      logic signed [3:0]    encoder_delta;
   } req_type;

   typedef struct packed {
      logic [3:0] event_code;
      logic       urgent;
      logic       last_event;
   } rsp_type;

   // One classified tick: a bit per event slot and the code of each slot.
   typedef struct packed {
      logic [NumEvents-1:0]      fire;
      logic [NumEvents-1:0][3:0] code;
   } tick_type;

   typedef struct packed {
      logic [TouchBits-1:0] left_on;
      logic [TouchBits-1:0] left_off;
      logic [TouchBits-1:0] right_on;
      logic [TouchBits-1:0] right_off;
      logic [3:0]           debounce;
      logic [15:0]          long_time;
      logic [15:0]          hold_limit;
      logic [6:0]           detent;
   } cfg_type;

endpackage

### rtl/core/key_event_scanner.sv
// Key event scanner: classifies poll ticks into key events and queues them out.
// Uses kes_pkg, kes_front, kes_queue and kes_back.
//
// Usage: each req beat is one poll tick (time, touch readings, paddle and button
// levels, encoder delta), offered with req_push while req_full is low. The
// front end updates all key state in the cycle the tick is taken and hands a
// set of flagged event slots to a two-entry tick queue. The back end sends one
// event per cycle while the result buffer has room, in slot order, into that
// two-entry result buffer read with rsp_pop while rsp_empty is low; the last
// event of a tick has last_event set. A tick with no events produces nothing.
// A tick passes the tick queue and the result buffer before its first event is
// read, and holds the back end until its last (of up to seven) is sent.
// If the receiver stalls, the result buffer and then the tick queue fill and
// req_full rises; nothing is lost. Reset is synchronous and clears all key
// state, queues and registers (to their documented defaults). Registers are
// written through csr_write_enable, csr_index and csr_write_data.
module key_event_scanner import kes_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   cfg_type  cfg_ff;
   tick_type tick_in, tick_out;
   logic     take, q_empty, q_done;

   assign take = req_push && !req_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_on    <= '0;
         cfg_ff.left_off   <= '1;
         cfg_ff.right_on   <= '0;
         cfg_ff.right_off  <= '1;
         cfg_ff.debounce   <= 4'd3;
         cfg_ff.long_time  <= 16'd1000;
         cfg_ff.hold_limit <= 16'd5000;
         cfg_ff.detent     <= 7'd2;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_LEFT_ON:   cfg_ff.left_on    <= csr_write_data;
            REG_LEFT_OFF:  cfg_ff.left_off   <= csr_write_data;
            REG_RIGHT_ON:  cfg_ff.right_on   <= csr_write_data;
            REG_RIGHT_OFF: cfg_ff.right_off  <= csr_write_data;
            REG_DEBOUNCE:  cfg_ff.debounce   <= csr_write_data[3:0];
            REG_LONG_TIME: cfg_ff.long_time  <= csr_write_data;
            REG_HOLD_LIM:  cfg_ff.hold_limit <= csr_write_data;
            REG_DETENT:    cfg_ff.detent     <= csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   kes_front u_front (
      .clock(clock), .reset(reset), .take(take), .req(req_data), .cfg(cfg_ff),
      .tick(tick_in)
   );

   kes_queue u_queue (
      .clock(clock), .reset(reset), .push(take), .push_data(tick_in),
      .full(req_full), .pop(q_done), .empty(q_empty), .pop_data(tick_out)
   );

   kes_back u_back (
      .clock(clock), .reset(reset), .tick_valid(!q_empty), .tick(tick_out),
      .tick_done(q_done), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_data(rsp_data)
   );

`ifndef SYNTHESIS
   a_urgent_release: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.urgent == (rsp_data.event_code < EV_ENC_CW &&
      rsp_data.event_code[0])) else $error("urgent flag mismatch");
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.event_code <= EV_AUX_LONG)
      else $error("event code out of range");
   a_done_needs_tick: assert property (@(posedge clock) disable iff (reset)
      q_done |-> !q_empty) else $error("tick retired from empty queue");
`endif

endmodule

### rtl/core/kes_front.sv
// Front end: holds the scanner state and turns each tick into a set of events.
// Depends on kes_pkg.
module kes_front import kes_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     take,
   input  req_type  req,
   input  cfg_type  cfg,
   output tick_type tick
);

   logic [1:0]                touch_down_ff, touch_down_in;
   logic [1:0][TimeBits-1:0]  touch_start_ff, touch_start_in;
   logic [1:0]                paddle_ff, paddle_in;
   logic signed [7:0]         acc_ff, acc_in;
   logic [1:0]                bpress_ff, bpress_in;
   logic [1:0]                bpend_ff, bpend_in;
   logic [1:0][3:0]           bcount_ff, bcount_in;
   logic [1:0][TimeBits-1:0]  btime_ff, btime_in;
   logic [1:0]                blong_ff, blong_in;

   logic [1:0][TouchBits-1:0] reading, on_lvl, off_lvl;
   logic [1:0]                closed, bnow;
   logic signed [8:0]         sum;
   logic signed [7:0]         sat, steps;
   logic [1:0]                t_ev, t_up, b_short, b_long;
   logic [1:0][3:0]           cnt;

   always_comb begin
      reading = {req.right_touch_reading, req.left_touch_reading};
      on_lvl  = {cfg.right_on, cfg.left_on};
      off_lvl = {cfg.right_off, cfg.left_off};
      closed  = {req.dah_paddle_closed, req.dit_paddle_closed};
      bnow    = {req.aux_button_pressed, req.encoder_button_pressed};
      touch_down_in  = touch_down_ff;
      touch_start_in = touch_start_ff;
      paddle_in = paddle_ff;
      bpress_in = bpress_ff;
      bpend_in  = bpend_ff;
      bcount_in = bcount_ff;
      btime_in  = btime_ff;
      blong_in  = blong_ff;
      t_ev = '0;
      t_up = '0;
      b_short = '0;
      b_long = '0;
      cnt = '0;
      tick.fire = '0;
      for (int i = 0; i < 2; i++) begin
         if (!touch_down_ff[i] && reading[i] < on_lvl[i]) begin
            touch_down_in[i] = 1'b1;
            touch_start_in[i] = req.now_ms;
            t_ev[i] = 1'b1;
         end else if (touch_down_ff[i] && (reading[i] > off_lvl[i] ||
               (req.now_ms - touch_start_ff[i]) >= TimeBits'(cfg.hold_limit))) begin
            touch_down_in[i] = 1'b0;
            t_ev[i] = 1'b1;
            t_up[i] = 1'b1;
         end
         tick.fire[i]   = t_ev[i];
         tick.code[i]   = 4'(2 * i) | {3'b0, t_up[i]};
         tick.fire[2+i] = closed[i] != paddle_ff[i];
         tick.code[2+i] = 4'(4 + 2 * i) | {3'b0, !closed[i]};
         paddle_in[i]   = closed[i];

         if (bnow[i] != bpress_ff[i]) begin
            if (bnow[i] == bpend_ff[i]) begin
               cnt[i] = (bcount_ff[i] < 4'd15) ? bcount_ff[i] + 4'd1 : bcount_ff[i];
               bcount_in[i] = cnt[i];
               if (cnt[i] >= cfg.debounce) begin
                  bpress_in[i] = bnow[i];
                  bcount_in[i] = '0;
                  if (bnow[i]) begin
                     btime_in[i] = req.now_ms;
                     blong_in[i] = 1'b0;
                  end else if (!blong_ff[i]) begin
                     b_short[i] = 1'b1;
                  end
               end
            end else begin
               bpend_in[i] = bnow[i];
               bcount_in[i] = 4'd1;
            end
         end else begin
            bcount_in[i] = '0;
            bpend_in[i] = bpress_ff[i];
         end
         if (bpress_in[i] && !blong_in[i] &&
               (req.now_ms - btime_in[i]) >= TimeBits'(cfg.long_time)) begin
            blong_in[i] = 1'b1;
            b_long[i] = 1'b1;
         end
      end
      // Short and long cannot both fire in one tick for the same button.
      tick.fire[5] = b_short[0] | b_long[0];
      tick.code[5] = b_long[0] ? EV_ENC_LONG : EV_ENC_SHORT;
      tick.fire[6] = b_short[1] | b_long[1];
      tick.code[6] = b_long[1] ? EV_AUX_LONG : EV_AUX_SHORT;

      sum = 9'(acc_ff) + 9'(req.encoder_delta);
      if (sum > 9'sd127) sat = 8'sd127;
      else if (sum < -9'sd128) sat = -8'sd128;
      else sat = sum[7:0];
      steps = (cfg.detent == '0) ? 8'sd1 : {1'b0, cfg.detent};
      acc_in = sat;
      tick.fire[4] = 1'b0;
      tick.code[4] = EV_ENC_CW;
      if (sat >= steps) begin
         acc_in = '0;
         tick.fire[4] = 1'b1;
      end else if (sat <= -steps) begin
         acc_in = '0;
         tick.fire[4] = 1'b1;
         tick.code[4] = EV_ENC_CCW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touch_down_ff <= '0;
         touch_start_ff <= '0;
         paddle_ff <= '0;
         acc_ff <= '0;
         bpress_ff <= '0;
         bpend_ff <= '0;
         bcount_ff <= '0;
         btime_ff <= '0;
         blong_ff <= '0;
      end else if (take) begin
         touch_down_ff <= touch_down_in;
         touch_start_ff <= touch_start_in;
         paddle_ff <= paddle_in;
         acc_ff <= acc_in;
         bpress_ff <= bpress_in;
         bpend_ff <= bpend_in;
         bcount_ff <= bcount_in;
         btime_ff <= btime_in;
         blong_ff <= blong_in;
      end
   end

endmodule

### rtl/core/kes_queue.sv
// Two-entry queue of classified ticks between the front and the back end.
// Depends on kes_pkg.
module kes_queue import kes_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  tick_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output tick_type pop_data
);

   tick_type   mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign pop_data = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push && !full) wptr_ff <= !wptr_ff;
         if (pop && !empty) rptr_ff <= !rptr_ff;
         count_ff <= count_ff + 2'(push && !full) - 2'(pop && !empty);
      end
   end

endmodule

### rtl/core/kes_back.sv
// Back end: walks the event slots of one tick and feeds a two-entry result buffer.
// Depends on kes_pkg.
module kes_back import kes_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     tick_valid,
   input  tick_type tick,
   output logic     tick_done,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

   logic [NumEvents-1:0] left_ff, left_in;
   logic                 busy_ff;
   rsp_type              buf_ff [2];
   logic                 wptr_ff, rptr_ff;
   logic [1:0]           count_ff;
   logic [NumEvents-1:0] pend, low_bit, rest;
   logic [2:0]           idx;
   logic                 can_put, put;
   rsp_type              item;

   // Pending slots: a fresh tick is loaded on the cycle it is taken.
   assign pend    = busy_ff ? left_ff : tick.fire;
   assign low_bit = pend & (~pend + NumEvents'(1));
   assign rest    = pend & ~low_bit;
   assign can_put = (count_ff != 2'd2) || (rsp_pop && !rsp_empty);

   always_comb begin
      idx = '0;
      for (int i = NumEvents - 1; i >= 0; i--) begin
         if (low_bit[i]) idx = 3'(i);
      end
      item.event_code = tick.code[idx];
      item.urgent     = (tick.code[idx] < EV_ENC_CW) && tick.code[idx][0];
      item.last_event = rest == '0;
      put = (busy_ff || tick_valid) && pend != '0 && can_put;
      tick_done = tick_valid && (pend == '0 || (put && rest == '0));
      left_in = put ? rest : pend;
   end

   assign rsp_empty = count_ff == 2'd0;
   assign rsp_data  = buf_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (put) buf_ff[wptr_ff] <= item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         left_ff <= '0;
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= tick_valid && !tick_done;
         left_ff <= left_in;
         if (put) wptr_ff <= !wptr_ff;
         if (rsp_pop && !rsp_empty) rptr_ff <= !rptr_ff;
         count_ff <= count_ff + 2'(put) - 2'(rsp_pop && !rsp_empty);
      end
   end

endmodule

### test/tb_top.sv
// Self-checking testbench for the key event scanner: directed table, then random ticks.
// Depends on kes_pkg and key_event_scanner; predicts each tick's events and compares them.
module tb_top;
   import kes_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   req_type     req_data;
   logic        rsp_empty;
   logic        rsp_pop;
   rsp_type     rsp_data;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [15:0] csr_write_data;

   key_event_scanner dut (.*);

   // Shadow of the block's registers and key state.
   logic [15:0] lvl_left_on, lvl_left_off, lvl_right_on, lvl_right_off;
   logic [3:0]  deb_count;
   logic [15:0] long_ms, hold_ms;
   logic [6:0]  detent;
   logic        pad_down [2];
   logic [31:0] pad_start [2];
   logic        paddle_on [2];
   int          enc_acc;
   logic        btn_state [2];
   logic        btn_pend [2];
   logic [3:0]  btn_cnt [2];
   logic [31:0] btn_since [2];
   logic        btn_long [2];

   rsp_type     pending_events [$];
   int          error_count;
   int          ticks_sent;

   // Session state for the random well-formed touch/button sequences.
   logic [31:0] clock_ms;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report(input string what, input rsp_type got, input rsp_type want);
      $display("mismatch %0s: got code %0d urg %0d last %0d, want code %0d urg %0d last %0d",
               what, got.event_code, got.urgent, got.last_event,
               want.event_code, want.urgent, want.last_event);
      error_count++;
   endtask

   function automatic void clear_state();
      lvl_left_on = 16'd0; lvl_left_off = 16'hFFFF;
      lvl_right_on = 16'd0; lvl_right_off = 16'hFFFF;
      deb_count = 4'd3; long_ms = 16'd1000; hold_ms = 16'd5000; detent = 7'd2;
      for (int i = 0; i < 2; i++) begin
         pad_down[i] = 1'b0; pad_start[i] = '0; paddle_on[i] = 1'b0;
         btn_state[i] = 1'b0; btn_pend[i] = 1'b0; btn_cnt[i] = '0;
         btn_since[i] = '0; btn_long[i] = 1'b0;
      end
      enc_acc = 0;
   endfunction

   function automatic void shadow_write(input logic [2:0] idx, input logic [15:0] val);
      case (idx)
         REG_LEFT_ON:   lvl_left_on = val;
         REG_LEFT_OFF:  lvl_left_off = val;
         REG_RIGHT_ON:  lvl_right_on = val;
         REG_RIGHT_OFF: lvl_right_off = val;
         REG_DEBOUNCE:  deb_count = val[3:0];
         REG_LONG_TIME: long_ms = val;
         REG_HOLD_LIM:  hold_ms = val;
         REG_DETENT:    detent = val[6:0];
         default: ;
      endcase
   endfunction

   function automatic void add_event(input logic [3:0] code, input logic urg,
                                     inout rsp_type evs [$]);
      rsp_type e;
      e.event_code = code; e.urgent = urg; e.last_event = 1'b0;
      evs.push_back(e);
   endfunction

   function automatic void touch_step(input int i, input logic [15:0] rd,
                                      input logic [15:0] on_lvl, input logic [15:0] off_lvl,
                                      input logic [31:0] now, inout rsp_type evs [$]);
      logic [3:0] base;
      base = 4'(i * 2);
      if (!pad_down[i] && rd < on_lvl) begin
         pad_down[i] = 1'b1; pad_start[i] = now; add_event(base, 1'b0, evs);
      end else if (pad_down[i] && rd > off_lvl) begin
         pad_down[i] = 1'b0; add_event(base + 4'd1, 1'b1, evs);
      end else if (pad_down[i] && (now - pad_start[i]) >= {16'd0, hold_ms}) begin
         pad_down[i] = 1'b0; add_event(base + 4'd1, 1'b1, evs);
      end
   endfunction

   function automatic void button_step(input int i, input logic lvl, input logic [31:0] now,
                                       input logic [3:0] short_code,
                                       input logic [3:0] long_code, inout rsp_type evs [$]);
      if (lvl != btn_state[i]) begin
         if (lvl == btn_pend[i]) begin
            if (btn_cnt[i] < 4'd15) btn_cnt[i]++;
            if (btn_cnt[i] >= deb_count) begin
               btn_state[i] = lvl; btn_cnt[i] = '0;
               if (lvl) begin
                  btn_since[i] = now; btn_long[i] = 1'b0;
               end else if (!btn_long[i]) begin
                  add_event(short_code, 1'b0, evs);
               end
            end
         end else begin
            btn_pend[i] = lvl; btn_cnt[i] = 4'd1;
         end
      end else begin
         btn_cnt[i] = '0; btn_pend[i] = btn_state[i];
      end
      if (btn_state[i] && !btn_long[i] && (now - btn_since[i]) >= {16'd0, long_ms}) begin
         btn_long[i] = 1'b1; add_event(long_code, 1'b0, evs);
      end
   endfunction

   // Works out the events of one tick and updates the shadow state.
   function automatic void scan_tick(input req_type t, output rsp_type evs [$]);
      int steps;
      evs = {};
      touch_step(0, t.left_touch_reading, lvl_left_on, lvl_left_off, t.now_ms, evs);
      touch_step(1, t.right_touch_reading, lvl_right_on, lvl_right_off, t.now_ms, evs);
      if (t.dit_paddle_closed && !paddle_on[0]) begin
         paddle_on[0] = 1'b1; add_event(EV_DIT_DOWN, 1'b0, evs);
      end else if (!t.dit_paddle_closed && paddle_on[0]) begin
         paddle_on[0] = 1'b0; add_event(EV_DIT_DOWN + 4'd1, 1'b1, evs);
      end
      if (t.dah_paddle_closed && !paddle_on[1]) begin
         paddle_on[1] = 1'b1; add_event(EV_DAH_DOWN, 1'b0, evs);
      end else if (!t.dah_paddle_closed && paddle_on[1]) begin
         paddle_on[1] = 1'b0; add_event(EV_DAH_DOWN + 4'd1, 1'b1, evs);
      end
      enc_acc += int'(t.encoder_delta);
      if (enc_acc > 127) enc_acc = 127;
      if (enc_acc < -128) enc_acc = -128;
      steps = (detent == 0) ? 1 : int'(detent);
      if (enc_acc >= steps) begin
         enc_acc = 0; add_event(EV_ENC_CW, 1'b0, evs);
      end else if (enc_acc <= -steps) begin
         enc_acc = 0; add_event(EV_ENC_CCW, 1'b0, evs);
      end
      button_step(0, t.encoder_button_pressed, t.now_ms, EV_ENC_SHORT, EV_ENC_LONG, evs);
      button_step(1, t.aux_button_pressed, t.now_ms, EV_AUX_SHORT, EV_AUX_LONG, evs);
      if (evs.size() > 0) evs[evs.size() - 1].last_event = 1'b1;
   endfunction

   // Offers one tick; returns at the falling edge after it has been taken, with
   // req_push still high so that the next beat can follow without a gap.
   task automatic send_tick(input req_type t, input int want_n, input logic [3:0] want_first);
      rsp_type evs [$];
      scan_tick(t, evs);
      if (want_n >= 0 && evs.size() != want_n) begin
         $display("mismatch table row: expects %0d events, predictor gives %0d",
                  want_n, evs.size());
         error_count++;
      end
      if (want_n > 0 && evs.size() > 0 && evs[0].event_code != want_first) begin
         $display("mismatch table row: predictor first code %0d, table %0d",
                  evs[0].event_code, want_first);
         error_count++;
      end
      foreach (evs[k]) pending_events.push_back(evs[k]);
      req_data <= t;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      ticks_sent++;
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (pending_events.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      shadow_write(idx, val);
      csr_write_enable <= 1'b1; csr_index <= idx; csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Receiver: stalls in a pattern of its own, checks each accepted beat.
   initial begin
      int stall_phase;
      rsp_type want;
      rsp_pop = 1'b0;
      stall_phase = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (pending_events.size() == 0) begin
               $display("mismatch: unexpected event code %0d", rsp_data.event_code);
               error_count++;
            end else begin
               want = pending_events.pop_front();
               if (rsp_data.event_code !== want.event_code) report("code", rsp_data, want);
               else if (rsp_data.urgent !== want.urgent) report("urgent", rsp_data, want);
               else if (rsp_data.last_event !== want.last_event) report("last", rsp_data, want);
            end
         end
         @(negedge clock);
         stall_phase++;
         if ((stall_phase / 200) % 3 == 0) rsp_pop <= 1'b1;
         else if (stall_phase % 7 < 3) rsp_pop <= 1'b0;
         else rsp_pop <= ($urandom_range(0, 3) != 0);
      end
   end

   initial begin
      #3000000;
      $display("CHECKS FAILED");
      $finish;
   end

   typedef struct {
      logic [31:0] now;
      logic [15:0] left, right;
      logic [3:0]  levels;   // dit, dah, encoder button, aux button
      logic [3:0]  delta;
      int          n;        // expected event count, -1 where left to the predictor
      logic [3:0]  first;
   } row_type;

   function automatic req_type make_tick(input logic [31:0] now, input logic [15:0] l,
                                         input logic [15:0] r, input logic [3:0] lv,
                                         input logic [3:0] d);
      req_type t;
      t.now_ms = now; t.left_touch_reading = l; t.right_touch_reading = r;
      {t.dit_paddle_closed, t.dah_paddle_closed,
       t.encoder_button_pressed, t.aux_button_pressed} = lv;
      t.encoder_delta = d;
      return t;
   endfunction

   task automatic random_ticks(input int count);
      int burst;
      int sent;
      int gap;
      logic [3:0] lv;
      logic [15:0] lr, rr;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst && sent < count; b++) begin
            clock_ms += ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 400);
            // Mostly button levels that hold for runs, so debounce and long press resolve.
            lv = {$urandom_range(0, 3) == 0 ? ~paddle_on[0] : paddle_on[0],
                  $urandom_range(0, 3) == 0 ? ~paddle_on[1] : paddle_on[1],
                  $urandom_range(0, 5) == 0 ? ~btn_pend[0] : btn_pend[0],
                  $urandom_range(0, 5) == 0 ? ~btn_pend[1] : btn_pend[1]};
            lr = ($urandom_range(0, 7) == 0) ? 16'($urandom) : (pad_down[0] ?
                 16'($urandom_range(0, 40000)) : 16'($urandom_range(20000, 65535)));
            rr = ($urandom_range(0, 7) == 0) ? 16'($urandom) : (pad_down[1] ?
                 16'($urandom_range(0, 40000)) : 16'($urandom_range(20000, 65535)));
            send_tick(make_tick(clock_ms, lr, rr, lv, 4'($urandom)), -1, 4'd0);
            sent++;
         end
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   initial begin
      row_type rows [$];
      error_count = 0; ticks_sent = 0;
      clear_state();
      reset = 1'b1; req_push = 1'b0; req_data = '0;
      csr_write_enable = 1'b0; csr_index = REG_LEFT_ON; csr_write_data = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Directed table under reset values: quiet tick, paddle edges, encoder both ways, button presses.
      rows = '{
         '{32'd0,       16'hFFFF, 16'hFFFF, 4'b0000, 4'd0,    0, 4'd0},
         '{32'd1,       16'd0,    16'd0,    4'b1100, 4'd0,    2, EV_DIT_DOWN},
         '{32'd2,       16'd0,    16'd0,    4'b0000, 4'd7,    3, EV_DIT_DOWN + 4'd1},
         '{32'd3,       16'd0,    16'd0,    4'b0000, 4'h8,    1, EV_ENC_CCW},
         '{32'd4,       16'd0,    16'd0,    4'b0011, 4'd1,   -1, 4'd0},
         '{32'd5,       16'd0,    16'd0,    4'b0011, 4'd0,   -1, 4'd0},
         '{32'd6,       16'd0,    16'd0,    4'b0011, 4'd0,    0, 4'd0},
         '{32'd2000,    16'd0,    16'd0,    4'b0011, 4'd0,    2, EV_ENC_LONG},
         '{32'd2001,    16'd0,    16'd0,    4'b0000, 4'd0,    0, 4'd0},
         '{32'd2002,    16'd0,    16'd0,    4'b0000, 4'd0,    0, 4'd0},
         '{32'd2003,    16'd0,    16'd0,    4'b0000, 4'd0,    0, 4'd0},
         '{32'd2004,    16'd0,    16'd0,    4'b0010, 4'd0,   -1, 4'd0},
         '{32'hFFFFFFFF,16'd0,    16'd0,    4'b0010, 4'd0,   -1, 4'd0}
      };
      foreach (rows[k])
         send_tick(make_tick(rows[k].now, rows[k].left, rows[k].right, rows[k].levels,
                             rows[k].delta), rows[k].n, rows[k].first);
      wait_drained();

      // Extreme settings: wide hysteresis, zero hold and long time, zero debounce and detent.
      write_reg(REG_LEFT_ON, 16'hFFFF); write_reg(REG_LEFT_OFF, 16'd0);
      write_reg(REG_RIGHT_ON, 16'd100); write_reg(REG_RIGHT_OFF, 16'd200);
      write_reg(REG_DEBOUNCE, 16'd0); write_reg(REG_LONG_TIME, 16'd0);
      write_reg(REG_HOLD_LIM, 16'd0); write_reg(REG_DETENT, 16'd0);
      rows = '{
         '{32'h10,  16'd0,     16'd50,  4'b1111, 4'd7,  6, EV_LEFT_DOWN},
         '{32'h10,  16'd0,     16'd150, 4'b1111, 4'd7, -1, 4'd0},
         '{32'h11,  16'hFFFE,  16'd250, 4'b0000, 4'h9, -1, 4'd0},
         '{32'h12,  16'hFFFF,  16'd99,  4'b0000, 4'd0, -1, 4'd0},
         '{32'h13,  16'hFFFF,  16'd150, 4'b0000, 4'd0, -1, 4'd0}
      };
      foreach (rows[k])
         send_tick(make_tick(rows[k].now, rows[k].left, rows[k].right, rows[k].levels,
                             rows[k].delta), rows[k].n, rows[k].first);
      wait_drained();
      // Drive the accumulator upward with a detent of 64.
      write_reg(REG_DETENT, 16'd64);
      for (int k = 0; k < 24; k++)
         send_tick(make_tick(32'h20 + k, 16'hFFFF, 16'hFFFF, 4'b0000, 4'd7), -1, 4'd0);
      wait_drained();

      clock_ms = 32'hFFFF_F000;
      for (int phase = 0; phase < 4; phase++) begin
         write_reg(REG_LEFT_ON, 16'($urandom_range(10000, 40000)));
         write_reg(REG_LEFT_OFF, 16'($urandom_range(30000, 65535)));
         write_reg(REG_RIGHT_ON, 16'($urandom_range(10000, 40000)));
         write_reg(REG_RIGHT_OFF, 16'($urandom_range(30000, 65535)));
         write_reg(REG_DEBOUNCE, phase == 3 ? 16'd15 : 16'($urandom_range(1, 4)));
         write_reg(REG_LONG_TIME, phase == 2 ? 16'hFFFF : 16'($urandom_range(0, 1500)));
         write_reg(REG_HOLD_LIM, phase == 1 ? 16'hFFFF : 16'($urandom_range(0, 3000)));
         write_reg(REG_DETENT, phase == 0 ? 16'd1 : 16'($urandom_range(1, 8)));
         random_ticks(70);
         wait_drained();
      end

      if (error_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

### files.f
rtl/core/kes_pkg.sv
rtl/core/kes_front.sv
rtl/core/kes_queue.sv
rtl/core/kes_back.sv
rtl/core/key_event_scanner.sv
test/tb_top.sv
